[hw/rtl/psr_pkg.sv]
// shared types, widths and helpers for the point scale/rotate pipeline
// no dependencies; every other file uses this package by scoped names
package psr_pkg;

    // intermediates are saturated to +-2^40, so 42 signed bits hold every stage value
    localparam int VAL_W      = 42;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = VAL_W + COEF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int OUT_W      = 32;
    localparam int ZOOM_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [SUM_W-1:0] STAGE_LIMIT = SUM_W'(64'sh0000_0100_0000_0000);
    localparam logic signed [SUM_W-1:0] NEG_LIMIT   = -STAGE_LIMIT;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ZOOM   = 3'd0,
        REG_Z_GAIN = 3'd1,
        REG_COS_X  = 3'd2,
        REG_SIN_X  = 3'd3,
        REG_COS_Y  = 3'd4,
        REG_SIN_Y  = 3'd5,
        REG_COS_Z  = 3'd6,
        REG_SIN_Z  = 3'd7
    } cfg_idx_t;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic [ZOOM_W-1:0] zoom;
        coef_t             z_gain;
        coef_t             cos_x;
        coef_t             sin_x;
        coef_t             cos_y;
        coef_t             sin_y;
        coef_t             cos_z;
        coef_t             sin_z;
    } cfg_t;

    // scaled point
    typedef struct packed {
        val_t x;
        val_t y;
        val_t z;
    } pt_t;

    // one axis rotation: a and b are rotated, keep rides along
    typedef struct packed {
        val_t a;
        val_t b;
        val_t keep;
    } rot_t;

    function automatic val_t sat_val(input logic signed [SUM_W-1:0] v);
        val_t r;
        if (v > STAGE_LIMIT) begin
            r = STAGE_LIMIT[VAL_W-1:0];
        end else if (v < NEG_LIMIT) begin
            r = NEG_LIMIT[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/psr_if.sv]
// valid/ready channel interfaces for points in and transformed results out
// depends on psr_pkg for the result width
interface psr_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] src_x;
    logic signed [COORD_WIDTH-1:0] src_y;
    logic signed [COORD_WIDTH-1:0] src_z;

    modport source (output valid, output src_x, output src_y, output src_z, input ready);
    modport sink   (input valid, input src_x, input src_y, input src_z, output ready);
endinterface

interface psr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [psr_pkg::OUT_W-1:0] out_x;
    logic signed [psr_pkg::OUT_W-1:0] out_y;
    logic signed [psr_pkg::OUT_W-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

[hw/rtl/psr_cfg_regs.sv]
// configuration registers: zoom, height gain and the six Q2.14 coefficients
// depends on psr_pkg
module psr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [psr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output psr_pkg::cfg_t                  cfg
);

    psr_pkg::cfg_t cfg_reg;
    psr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (psr_pkg::cfg_idx_t'(cfg_addr))
                psr_pkg::REG_ZOOM:   cfg_next.zoom   = cfg_wdata[psr_pkg::ZOOM_W-1:0];
                psr_pkg::REG_Z_GAIN: cfg_next.z_gain = cfg_wdata;
                psr_pkg::REG_COS_X:  cfg_next.cos_x  = cfg_wdata;
                psr_pkg::REG_SIN_X:  cfg_next.sin_x  = cfg_wdata;
                psr_pkg::REG_COS_Y:  cfg_next.cos_y  = cfg_wdata;
                psr_pkg::REG_SIN_Y:  cfg_next.sin_y  = cfg_wdata;
                psr_pkg::REG_COS_Z:  cfg_next.cos_z  = cfg_wdata;
                psr_pkg::REG_SIN_Z:  cfg_next.sin_z  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zoom   <= 8'd1;
            cfg_reg.z_gain <= 16'sd1;
            cfg_reg.cos_x  <= 16'sd16384;
            cfg_reg.sin_x  <= 16'sd0;
            cfg_reg.cos_y  <= 16'sd16384;
            cfg_reg.sin_y  <= 16'sd0;
            cfg_reg.cos_z  <= 16'sd16384;
            cfg_reg.sin_z  <= 16'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/psr_scale.sv]
// input stage: multiplies grid x, y by zoom and height by the height gain
// depends on psr_pkg and psr_in_if
module psr_scale #(
    parameter int COORD_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    psr_in_if.sink        point,
    input  psr_pkg::cfg_t cfg,
    output logic          out_valid,
    input  logic          out_ready,
    output psr_pkg::pt_t  out_pt
);

    logic                                          valid_reg;
    logic                                          en;
    logic signed [COORD_WIDTH+psr_pkg::ZOOM_W:0]   prod_x;
    logic signed [COORD_WIDTH+psr_pkg::ZOOM_W:0]   prod_y;
    logic signed [COORD_WIDTH+psr_pkg::COEF_W-1:0] prod_z;
    psr_pkg::pt_t                                  pt_reg;
    psr_pkg::pt_t                                  pt_next;

    // zoom is unsigned, so it gets a zero sign bit
    assign prod_x = point.src_x * $signed({1'b0, cfg.zoom});
    assign prod_y = point.src_y * $signed({1'b0, cfg.zoom});
    assign prod_z = point.src_z * cfg.z_gain;

    always_comb
    begin
        pt_next.x = psr_pkg::sat_val(psr_pkg::SUM_W'(prod_x));
        pt_next.y = psr_pkg::sat_val(psr_pkg::SUM_W'(prod_y));
        pt_next.z = psr_pkg::sat_val(psr_pkg::SUM_W'(prod_z));
    end

    assign en          = !valid_reg || out_ready;
    assign point.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && point.valid)
        begin
            pt_reg <= pt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pt    = pt_reg;

endmodule

[hw/rtl/psr_rot_stage.sv]
// one axis rotation in two stages: four products, then sums with
// truncation toward zero and saturation; depends on psr_pkg
module psr_rot_stage #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  psr_pkg::rot_t   in_rot,
    input  psr_pkg::coef_t  cos_c,
    input  psr_pkg::coef_t  sin_c,
    output logic            out_valid,
    input  logic            out_ready,
    output psr_pkg::rot_t   out_rot
);

    localparam logic signed [psr_pkg::SUM_W-1:0] RND =
        (psr_pkg::SUM_W'(1) << COEF_FRAC_BITS) - psr_pkg::SUM_W'(1);
    localparam logic signed [psr_pkg::SUM_W-1:0] NO_RND = '0;

    logic                                 v1_reg;
    logic                                 v2_reg;
    logic                                 en1;
    logic                                 en2;
    logic signed [psr_pkg::PROD_W-1:0]    ac_reg;
    logic signed [psr_pkg::PROD_W-1:0]    bs_reg;
    logic signed [psr_pkg::PROD_W-1:0]    as_reg;
    logic signed [psr_pkg::PROD_W-1:0]    bc_reg;
    psr_pkg::val_t                        keep1_reg;
    logic signed [psr_pkg::SUM_W-1:0]     sum_p;
    logic signed [psr_pkg::SUM_W-1:0]     sum_q;
    logic signed [psr_pkg::SUM_W-1:0]     quo_p;
    logic signed [psr_pkg::SUM_W-1:0]     quo_q;
    psr_pkg::rot_t                        rot_reg;
    psr_pkg::rot_t                        rot_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            ac_reg    <= in_rot.a * cos_c;
            bs_reg    <= in_rot.b * sin_c;
            as_reg    <= in_rot.a * sin_c;
            bc_reg    <= in_rot.b * cos_c;
            keep1_reg <= in_rot.keep;
        end
    end

    // p = a*c - b*s, q = a*s + b*c
    assign sum_p = psr_pkg::SUM_W'(ac_reg) - psr_pkg::SUM_W'(bs_reg);
    assign sum_q = psr_pkg::SUM_W'(as_reg) + psr_pkg::SUM_W'(bc_reg);

    // negative sums get a bias so the arithmetic shift rounds toward zero
    assign quo_p = (sum_p + (sum_p[psr_pkg::SUM_W-1] ? RND : NO_RND)) >>> COEF_FRAC_BITS;
    assign quo_q = (sum_q + (sum_q[psr_pkg::SUM_W-1] ? RND : NO_RND)) >>> COEF_FRAC_BITS;

    always_comb
    begin
        rot_next.a    = psr_pkg::sat_val(quo_p);
        rot_next.b    = psr_pkg::sat_val(quo_q);
        rot_next.keep = keep1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_rot   = rot_reg;

    a_stall_holds_products: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> v1_reg)
        else $error("product stage lost an item while stalled");

    a_result_from_products: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v2_reg) |-> $past(v1_reg))
        else $error("result stage valid without a product item");

    a_result_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (psr_pkg::SUM_W'(rot_reg.a) <= psr_pkg::STAGE_LIMIT
                    && psr_pkg::SUM_W'(rot_reg.a) >= psr_pkg::NEG_LIMIT
                    && psr_pkg::SUM_W'(rot_reg.b) <= psr_pkg::STAGE_LIMIT
                    && psr_pkg::SUM_W'(rot_reg.b) >= psr_pkg::NEG_LIMIT))
        else $error("rotated value outside saturation bound");

endmodule

[hw/rtl/point_scale_rotate_xyz_top.sv]
// an accepted point passes the scale register, then the product and result registers of the x, y and z stages
// throughput: one point per cycle while the output is not stalled; each rotation axis has its own four multipliers
// per-stage valid bits; a stall holds items in place and bubbles are squeezed out
// reset: asynchronous active low, clears the pipeline and loads zoom 1, gain 1, identity angles
// depends on psr_pkg, psr_if, psr_cfg_regs, psr_scale and psr_rot_stage
module point_scale_rotate_xyz_top #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int COORD_WIDTH    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [psr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    psr_in_if.sink                         point,
    psr_out_if.source                      result
);

    psr_pkg::cfg_t cfg;
    psr_pkg::pt_t  scaled;
    logic          sc_valid;
    logic          sc_ready;
    psr_pkg::rot_t rx_in;
    psr_pkg::rot_t rx_out;
    logic          rx_valid;
    logic          rx_ready;
    psr_pkg::rot_t ry_in;
    psr_pkg::rot_t ry_out;
    logic          ry_valid;
    logic          ry_ready;
    psr_pkg::rot_t rz_in;
    psr_pkg::rot_t rz_out;

    psr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    psr_scale #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point),
        .cfg       (cfg),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_pt    (scaled)
    );

    // about x: y and z rotate
    assign rx_in = '{a: scaled.y, b: scaled.z, keep: scaled.x};

    psr_rot_stage #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_rot    (rx_in),
        .cos_c     (cfg.cos_x),
        .sin_c     (cfg.sin_x),
        .out_valid (rx_valid),
        .out_ready (rx_ready),
        .out_rot   (rx_out)
    );

    // about y: a = z, b = x gives z' = z*c - x*s and x' = z*s + x*c
    assign ry_in = '{a: rx_out.b, b: rx_out.keep, keep: rx_out.a};

    psr_rot_stage #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_valid),
        .in_ready  (rx_ready),
        .in_rot    (ry_in),
        .cos_c     (cfg.cos_y),
        .sin_c     (cfg.sin_y),
        .out_valid (ry_valid),
        .out_ready (ry_ready),
        .out_rot   (ry_out)
    );

    // about z: x and y rotate, z rides along
    assign rz_in = '{a: ry_out.b, b: ry_out.keep, keep: ry_out.a};

    psr_rot_stage #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ry_valid),
        .in_ready  (ry_ready),
        .in_rot    (rz_in),
        .cos_c     (cfg.cos_z),
        .sin_c     (cfg.sin_z),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_rot   (rz_out)
    );

    // outputs keep the low 32 bits
    assign result.out_x = rz_out.a[psr_pkg::OUT_W-1:0];
    assign result.out_y = rz_out.b[psr_pkg::OUT_W-1:0];
    assign result.out_z = rz_out.keep[psr_pkg::OUT_W-1:0];

endmodule

[bench/psr_xform_checker.sv]
// result checker for point_scale_rotate_xyz_top: tracks register writes, predicts every
// accepted point and compares each accepted result with the oldest prediction
// depends on psr_pkg for register codes, widths and the register struct
module psr_xform_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [psr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic signed [15:0]             src_x,
    input  logic signed [15:0]             src_y,
    input  logic signed [15:0]             src_z,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [psr_pkg::OUT_W-1:0] out_x,
    input  logic signed [psr_pkg::OUT_W-1:0] out_y,
    input  logic signed [psr_pkg::OUT_W-1:0] out_z,
    output int                             fail_count,
    output int                             pending
);

    localparam int     FRAC_BITS  = 14;
    localparam longint WIDE_LIMIT = 64'sd1 << 40;

    typedef struct {
        logic signed [15:0]               px;
        logic signed [15:0]               py;
        logic signed [15:0]               pz;
        logic signed [psr_pkg::OUT_W-1:0] ex;
        logic signed [psr_pkg::OUT_W-1:0] ey;
        logic signed [psr_pkg::OUT_W-1:0] ez;
    } point_expect_t;

    psr_pkg::cfg_t regs;
    point_expect_t expected_points[$];

    function automatic longint clamp_wide(input longint v);
        longint r;
        if (v > WIDE_LIMIT) begin
            r = WIDE_LIMIT;
        end else if (v < -WIDE_LIMIT) begin
            r = -WIDE_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // drop the Q2.14 fraction, rounding toward zero
    function automatic longint drop_frac(input longint n);
        longint q;
        if (n >= 0) begin
            q = n >>> FRAC_BITS;
        end else begin
            q = -((-n) >>> FRAC_BITS);
        end
        return clamp_wide(q);
    endfunction

    function automatic point_expect_t transform_point(input psr_pkg::cfg_t c,
                                                      input logic signed [15:0] px,
                                                      input logic signed [15:0] py,
                                                      input logic signed [15:0] pz);
        point_expect_t r;
        longint        x;
        longint        y;
        longint        z;
        longint        nx;
        longint        ny;
        longint        nz;
        longint        cs;
        longint        sn;
        x = clamp_wide(longint'(px) * longint'({1'b0, c.zoom}));
        y = clamp_wide(longint'(py) * longint'({1'b0, c.zoom}));
        z = clamp_wide(longint'(pz) * longint'($signed(c.z_gain)));

        cs = longint'($signed(c.cos_x));
        sn = longint'($signed(c.sin_x));
        ny = drop_frac(y * cs - z * sn);
        nz = drop_frac(y * sn + z * cs);
        y  = ny;
        z  = nz;

        cs = longint'($signed(c.cos_y));
        sn = longint'($signed(c.sin_y));
        nx = drop_frac(x * cs + z * sn);
        nz = drop_frac(z * cs - x * sn);
        x  = nx;
        z  = nz;

        cs = longint'($signed(c.cos_z));
        sn = longint'($signed(c.sin_z));
        nx = drop_frac(x * cs - y * sn);
        ny = drop_frac(x * sn + y * cs);

        r.px = px;
        r.py = py;
        r.pz = pz;
        r.ex = nx[psr_pkg::OUT_W-1:0];
        r.ey = ny[psr_pkg::OUT_W-1:0];
        r.ez = z[psr_pkg::OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_expect_t want;
        if (!rst_n)
        begin
            regs.zoom   = 8'd1;
            regs.z_gain = 16'sd1;
            regs.cos_x  = 16'sd16384;
            regs.sin_x  = 16'sd0;
            regs.cos_y  = 16'sd16384;
            regs.sin_y  = 16'sd0;
            regs.cos_z  = 16'sd16384;
            regs.sin_z  = 16'sd0;
            expected_points.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            // results first: nothing accepted at this edge can already be out
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("checker: result (%0d, %0d, %0d) with no point outstanding",
                                 out_x, out_y, out_z);
                    fail_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (out_x !== want.ex || out_y !== want.ey || out_z !== want.ez)
                    begin
                        if (fail_count < 10)
                            $display({"checker: point (%0d, %0d, %0d) ",
                                      "expected (%0d, %0d, %0d) got (%0d, %0d, %0d)"},
                                     want.px, want.py, want.pz, want.ex, want.ey, want.ez,
                                     out_x, out_y, out_z);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                expected_points.push_back(transform_point(regs, src_x, src_y, src_z));

            if (cfg_we)
            begin
                case (psr_pkg::cfg_idx_t'(cfg_addr))
                    psr_pkg::REG_ZOOM:   regs.zoom   = cfg_wdata[psr_pkg::ZOOM_W-1:0];
                    psr_pkg::REG_Z_GAIN: regs.z_gain = cfg_wdata;
                    psr_pkg::REG_COS_X:  regs.cos_x  = cfg_wdata;
                    psr_pkg::REG_SIN_X:  regs.sin_x  = cfg_wdata;
                    psr_pkg::REG_COS_Y:  regs.cos_y  = cfg_wdata;
                    psr_pkg::REG_SIN_Y:  regs.sin_y  = cfg_wdata;
                    psr_pkg::REG_COS_Z:  regs.cos_z  = cfg_wdata;
                    psr_pkg::REG_SIN_Z:  regs.sin_z  = cfg_wdata;
                    default:    ;
                endcase
            end

            pending = expected_points.size();
        end
    end

endmodule

[bench/point_scale_rotate_xyz_top_tb.sv]
// stimulus and verdict for point_scale_rotate_xyz_top: register settings, points,
// bursty input, stalling output; checking is done by psr_xform_checker
// depends on psr_pkg, psr_if, the block itself and psr_xform_checker
module point_scale_rotate_xyz_top_tb;

    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 150000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_POINTS = 100;

    localparam logic signed [15:0] C_MIN = 16'sh8000;
    localparam logic signed [15:0] C_MAX = 16'sh7FFF;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [psr_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int n_sent     = 0;
    int n_settings = 0;
    int hold_seq   = 0;
    int burst_left = 4;
    bit steady     = 1'b0;
    int cycle_cnt  = 0;

    psr_in_if #(.COORD_WIDTH(16)) point_ch ();
    psr_out_if                    result_ch ();

    point_scale_rotate_xyz_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .point     (point_ch),
        .result    (result_ch)
    );

    psr_xform_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (point_ch.valid),
        .in_ready   (point_ch.ready),
        .src_x      (point_ch.src_x),
        .src_y      (point_ch.src_y),
        .src_z      (point_ch.src_z),
        .out_valid  (result_ch.valid),
        .out_ready  (result_ch.ready),
        .out_x      (result_ch.out_x),
        .out_y      (result_ch.out_y),
        .out_z      (result_ch.out_z),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    // valid low, junk on the fields, for a span set by n
    task automatic idle_point(input int n);
        point_ch.valid = 1'b0;
        repeat (n)
        begin
            point_ch.src_x = 16'($urandom);
            point_ch.src_y = 16'($urandom);
            point_ch.src_z = 16'($urandom);
            @(negedge clk);
        end
    endtask

    task automatic send_point(input logic signed [15:0] px,
                              input logic signed [15:0] py,
                              input logic signed [15:0] pz);
        point_ch.valid = 1'b1;
        point_ch.src_x = px;
        point_ch.src_y = py;
        point_ch.src_z = pz;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        @(negedge clk);
        n_sent++;
        if (!steady)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                idle_point($urandom_range(1, 8));
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
        end
    endtask

    task automatic wait_drained();
        idle_point(1);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input psr_pkg::cfg_idx_t idx,
                             input logic [psr_pkg::CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_setting(input logic [7:0] zm, input logic [15:0] gain,
                                input logic [15:0] cx, input logic [15:0] sx,
                                input logic [15:0] cy, input logic [15:0] sy,
                                input logic [15:0] cz, input logic [15:0] sz);
        write_reg(psr_pkg::REG_ZOOM, {8'd0, zm});
        write_reg(psr_pkg::REG_Z_GAIN, gain);
        write_reg(psr_pkg::REG_COS_X, cx);
        write_reg(psr_pkg::REG_SIN_X, sx);
        write_reg(psr_pkg::REG_COS_Y, cy);
        write_reg(psr_pkg::REG_SIN_Y, sy);
        write_reg(psr_pkg::REG_COS_Z, cz);
        write_reg(psr_pkg::REG_SIN_Z, sz);
        n_settings++;
    endtask

    function automatic logic [15:0] rand_coef();
        logic [15:0] v;
        if ($urandom_range(0, 7) == 0)
            v = 16'($urandom);
        else
            v = 16'($urandom_range(0, 32768) - 16384);
        return v;
    endfunction

    task automatic random_setting();
        logic [7:0]  zm;
        logic [15:0] gain;
        case ($urandom_range(0, 3))
            0:       zm = 8'd0;
            1:       zm = 8'd255;
            default: zm = 8'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 3))
            0:       gain = 16'd0;
            1:       gain = 16'($urandom);
            default: gain = 16'($urandom_range(0, 400) - 200);
        endcase
        load_setting(zm, gain, rand_coef(), rand_coef(), rand_coef(),
                     rand_coef(), rand_coef(), rand_coef());
    endtask

    function automatic logic signed [15:0] rand_coord();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = C_MIN;
                    1:       v = C_MAX;
                    2:       v = -16'sd1;
                    3:       v = 16'sd1;
                    default: v = 16'sd0;
                endcase
            end
            1:       v = 16'($urandom_range(0, 200) - 100);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // output side: stall modes that change now and then, plus one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int seen_hold;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        seen_hold = 0;
        tick      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_seq != seen_hold)
            begin
                seen_hold = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (!rst_n)
            begin
                result_ch.ready = 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       result_ch.ready = 1'b1;
                    1:       result_ch.ready = ($urandom_range(0, 3) != 0);
                    2:       result_ch.ready = ($urandom_range(0, 9) < 4);
                    default: result_ch.ready = ((tick % 5) != 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
        $display("FAIL point_scale_rotate_xyz_top");
        $finish;
    end

    initial
    begin
        point_ch.valid = 1'b0;
        point_ch.src_x = '0;
        point_ch.src_y = '0;
        point_ch.src_z = '0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values: unit gains, identity rotation
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(-16'sd1, 16'sd1, -16'sd1);
        send_point(C_MAX, C_MIN, 16'sd0);
        send_point(16'sd12345, -16'sd4321, 16'sd777);
        wait_drained();

        // 45 and 90 degree style angles, largest zoom, most negative gain
        load_setting(8'd255, 16'h8000, 16'sd11585, 16'sd11585, 16'sd0, 16'sd16384,
                     -16'sd11585, -16'sd11585);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_MAX, C_MIN, C_MAX);
        send_point(-16'sd1, -16'sd1, -16'sd1);
        send_point(16'sd1, -16'sd1, 16'sd1);
        send_point(16'sd3, 16'sd5, -16'sd7);
        wait_drained();

        // flat projection: height gain of zero
        load_setting(8'd7, 16'd0, -16'sd16384, 16'sd16384, 16'sd9459, -16'sd13377,
                     16'sd16384, 16'sd0);
        send_point(C_MAX, C_MIN, C_MAX);
        send_point(C_MIN, C_MAX, C_MIN);
        send_point(-16'sd3, 16'sd9, 16'sd1000);
        send_point(16'sd0, 16'sd0, C_MAX);
        wait_drained();

        // coefficients outside a real sine and cosine: values grow and outputs wrap
        load_setting(8'd255, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                     16'h7FFF, 16'h8000);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_MAX, C_MIN, C_MAX);
        send_point(C_MIN, C_MAX, C_MIN);
        send_point(16'sd100, -16'sd200, 16'sd300);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            random_setting();
            for (int i = 0; i < PHASE_POINTS; i++)
            begin
                // long output hold-off while the input keeps pushing
                if (ph == 1 && i == 20)
                begin
                    hold_seq++;
                    steady = 1'b1;
                end
                if (ph == 1 && i == 60)
                    steady = 1'b0;
                if (ph == 3 && i == 50)
                    wait_drained();
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            wait_drained();
        end

        $display("sent %0d points over %0d register settings: extremes, flat projection,",
                 n_sent, n_settings);
        $display("out-of-range coefficients with wrapped outputs, and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("PASS point_scale_rotate_xyz_top");
        else
            $display("FAIL point_scale_rotate_xyz_top");
        $finish;
    end

endmodule
